// ===== rtl/nearest_eight_point_select_unit_assert.svh =====
// Assertion macros shared by the nearest point select unit.
`ifndef NEAREST_EIGHT_POINT_SELECT_UNIT_ASSERT_SVH
`define NEAREST_EIGHT_POINT_SELECT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NEPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NEPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/neps_pkg.sv =====
// Shared types and constants of the nearest point select unit.
package neps_pkg;

    // Default sizes of the design.
    localparam int KEEP_COUNT_DEF = 8;
    localparam int COORD_BITS_DEF = 24;

    // Width of the rank field on the result channel.
    localparam int RANK_W = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_Z = 2'd2;

    // Control broadcast to every sort cell.
    typedef struct packed {
        logic ins;
        logic clr;
    } t_cell_ctl;

endpackage

// ===== rtl/neps_dist.sv =====
// Pipelined squared-distance unit: difference, magnitude, square, sum.
module neps_dist #(
    parameter int COORD_BITS = neps_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic [COORD_BITS-1:0]   i_z,
    input  logic                    i_final,
    input  logic [COORD_BITS-1:0]   i_ref_x,
    input  logic [COORD_BITS-1:0]   i_ref_y,
    input  logic [COORD_BITS-1:0]   i_ref_z,
    output logic                    o_vld,
    output logic                    o_final,
    output logic [2*COORD_BITS+1:0] o_dist,
    output logic [COORD_BITS-1:0]   o_x,
    output logic [COORD_BITS-1:0]   o_y,
    output logic [COORD_BITS-1:0]   o_z
);
    import neps_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int SQ_W = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 2;
    localparam int NSTG = 4;

    // Stage valid and final flags, plus the point carried along.
    logic [NSTG-1:0]       r_vld;
    logic [NSTG-1:0]       r_fin;
    logic [COORD_BITS-1:0] r_px [NSTG];
    logic [COORD_BITS-1:0] r_py [NSTG];
    logic [COORD_BITS-1:0] r_pz [NSTG];

    logic [DW-1:0]         r_dx, r_dy, r_dz;
    logic [COORD_BITS-1:0] r_mx, r_my, r_mz;
    logic [SQ_W-1:0]       r_sx, r_sy, r_sz;
    logic [DIST_W-1:0]     r_sum;

    logic [DW-1:0]         n_dx, n_dy, n_dz;
    logic [DW-1:0]         w_nx, w_ny, w_nz;
    logic [COORD_BITS-1:0] n_mx, n_my, n_mz;

    // Sign-extended differences; the magnitude always fits the coordinate width.
    always_comb begin
        n_dx = {i_x[COORD_BITS-1], i_x} - {i_ref_x[COORD_BITS-1], i_ref_x};
        n_dy = {i_y[COORD_BITS-1], i_y} - {i_ref_y[COORD_BITS-1], i_ref_y};
        n_dz = {i_z[COORD_BITS-1], i_z} - {i_ref_z[COORD_BITS-1], i_ref_z};
        w_nx = ~r_dx + DW'(1);
        w_ny = ~r_dy + DW'(1);
        w_nz = ~r_dz + DW'(1);
        n_mx = r_dx[DW-1] ? w_nx[COORD_BITS-1:0] : r_dx[COORD_BITS-1:0];
        n_my = r_dy[DW-1] ? w_ny[COORD_BITS-1:0] : r_dy[COORD_BITS-1:0];
        n_mz = r_dz[DW-1] ? w_nz[COORD_BITS-1:0] : r_dz[COORD_BITS-1:0];
    end

    // Stage flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_vld};
        end
    end

    // Datapath registers advance together with the flags.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin   <= {r_fin[NSTG-2:0], i_final};
            r_px[0] <= i_x;
            r_py[0] <= i_y;
            r_pz[0] <= i_z;
            for (int k = 1; k < NSTG; k++) begin
                r_px[k] <= r_px[k-1];
                r_py[k] <= r_py[k-1];
                r_pz[k] <= r_pz[k-1];
            end
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dz  <= n_dz;
            r_mx  <= n_mx;
            r_my  <= n_my;
            r_mz  <= n_mz;
            r_sx  <= SQ_W'(r_mx) * SQ_W'(r_mx);
            r_sy  <= SQ_W'(r_my) * SQ_W'(r_my);
            r_sz  <= SQ_W'(r_mz) * SQ_W'(r_mz);
            r_sum <= DIST_W'(r_sx) + DIST_W'(r_sy) + DIST_W'(r_sz);
        end
    end

    assign o_vld   = r_vld[NSTG-1];
    assign o_final = r_fin[NSTG-1];
    assign o_dist  = r_sum;
    assign o_x     = r_px[NSTG-1];
    assign o_y     = r_py[NSTG-1];
    assign o_z     = r_pz[NSTG-1];

endmodule

// ===== rtl/neps_cell.sv =====
// One slot of the sorted insertion chain.
module neps_cell #(
    parameter int COORD_BITS = neps_pkg::COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  neps_pkg::t_cell_ctl     i_ctl,
    input  logic [2*COORD_BITS+1:0] i_dist,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic [COORD_BITS-1:0]   i_z,
    input  logic                    i_lt_prev,
    input  logic                    i_prev_full,
    input  logic [2*COORD_BITS+1:0] i_prev_dist,
    input  logic [COORD_BITS-1:0]   i_prev_x,
    input  logic [COORD_BITS-1:0]   i_prev_y,
    input  logic [COORD_BITS-1:0]   i_prev_z,
    output logic                    o_lt,
    output logic                    o_full,
    output logic [2*COORD_BITS+1:0] o_dist,
    output logic [COORD_BITS-1:0]   o_x,
    output logic [COORD_BITS-1:0]   o_y,
    output logic [COORD_BITS-1:0]   o_z,
    output logic                    o_nxt_full,
    output logic [2*COORD_BITS+1:0] o_nxt_dist,
    output logic [COORD_BITS-1:0]   o_nxt_x,
    output logic [COORD_BITS-1:0]   o_nxt_y,
    output logic [COORD_BITS-1:0]   o_nxt_z
);
    import neps_pkg::*;

    localparam int DIST_W = 2 * COORD_BITS + 2;

    logic                  r_full;
    logic [DIST_W-1:0]     r_dist;
    logic [COORD_BITS-1:0] r_x, r_y, r_z;

    logic                  n_full;
    logic [DIST_W-1:0]     n_dist;
    logic [COORD_BITS-1:0] n_x, n_y, n_z;

    // The new point lands here when it beats this slot but not the one before;
    // every slot after the landing point takes its left neighbor's entry.
    always_comb begin
        o_lt   = !r_full || (i_dist < r_dist);
        n_full = r_full;
        n_dist = r_dist;
        n_x    = r_x;
        n_y    = r_y;
        n_z    = r_z;
        if (i_lt_prev) begin
            n_full = i_prev_full;
            n_dist = i_prev_dist;
            n_x    = i_prev_x;
            n_y    = i_prev_y;
            n_z    = i_prev_z;
        end else if (o_lt) begin
            n_full = 1'b1;
            n_dist = i_dist;
            n_x    = i_x;
            n_y    = i_y;
            n_z    = i_z;
        end
    end

    // Occupancy flag; a clear empties the slot as its updated contents are handed off.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_ctl.clr) begin
            r_full <= 1'b0;
        end else if (i_ctl.ins) begin
            r_full <= n_full;
        end
    end

    // Slot contents.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            r_dist <= n_dist;
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
        end
    end

    assign o_full     = r_full;
    assign o_dist     = r_dist;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_z        = r_z;
    assign o_nxt_full = n_full;
    assign o_nxt_dist = n_dist;
    assign o_nxt_x    = n_x;
    assign o_nxt_y    = n_y;
    assign o_nxt_z    = n_z;

endmodule

// ===== rtl/neps_drain.sv =====
// Unload shift chain that sends out a finished list one entry per cycle while i_ready is high.
module neps_drain #(
    parameter int KEEP_COUNT = neps_pkg::KEEP_COUNT_DEF,
    parameter int COORD_BITS = neps_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [KEEP_COUNT-1:0]                    i_full,
    input  logic [KEEP_COUNT-1:0][2*COORD_BITS+1:0]  i_dist,
    input  logic [KEEP_COUNT-1:0][COORD_BITS-1:0]    i_x,
    input  logic [KEEP_COUNT-1:0][COORD_BITS-1:0]    i_y,
    input  logic [KEEP_COUNT-1:0][COORD_BITS-1:0]    i_z,
    output logic                                     o_can_load,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [COORD_BITS-1:0]                    o_x,
    output logic [COORD_BITS-1:0]                    o_y,
    output logic [COORD_BITS-1:0]                    o_z,
    output logic [neps_pkg::RANK_W-1:0]              o_rank,
    output logic [2*COORD_BITS+1:0]                  o_dist,
    output logic                                     o_last
);
    import neps_pkg::*;

    localparam int DIST_W = 2 * COORD_BITS + 2;

    logic [KEEP_COUNT-1:0] r_vld;
    logic [DIST_W-1:0]     r_dist [KEEP_COUNT];
    logic [COORD_BITS-1:0] r_x [KEEP_COUNT];
    logic [COORD_BITS-1:0] r_y [KEEP_COUNT];
    logic [COORD_BITS-1:0] r_z [KEEP_COUNT];
    logic [RANK_W-1:0]     r_rank;

    logic [KEEP_COUNT:0]   w_vld_ext;
    logic                  w_pop;

    // Filled entries form a prefix, so the head is last when its neighbor is empty.
    assign w_vld_ext  = {1'b0, r_vld};
    assign w_pop      = r_vld[0] && i_ready;
    assign o_can_load = !r_vld[0] || (i_ready && !w_vld_ext[1]);

    // Valid flags and rank counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rank <= '0;
        end else if (i_load) begin
            r_vld  <= i_full;
            r_rank <= '0;
        end else if (w_pop) begin
            r_vld  <= w_vld_ext[KEEP_COUNT:1];
            r_rank <= r_rank + RANK_W'(1);
        end
    end

    // Entry payload: parallel load from the sort chain, then shift toward the head.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < KEEP_COUNT; k++) begin
                r_dist[k] <= i_dist[k];
                r_x[k]    <= i_x[k];
                r_y[k]    <= i_y[k];
                r_z[k]    <= i_z[k];
            end
        end else if (w_pop) begin
            for (int k = 0; k < KEEP_COUNT - 1; k++) begin
                r_dist[k] <= r_dist[k+1];
                r_x[k]    <= r_x[k+1];
                r_y[k]    <= r_y[k+1];
                r_z[k]    <= r_z[k+1];
            end
        end
    end

    assign o_valid = r_vld[0];
    assign o_x     = r_x[0];
    assign o_y     = r_y[0];
    assign o_z     = r_z[0];
    assign o_dist  = r_dist[0];
    assign o_rank  = r_rank;
    assign o_last  = !w_vld_ext[1];

endmodule

// ===== rtl/nearest_eight_point_select_unit.sv =====
// Throughput: one request per cycle, while not stalled, through a 4-stage distance
// pipeline and a sort chain. A list drains one result per cycle while the receiver is
// ready; a final request waits at the pipeline's end while the previous list is still
// draining, and holds the input back for that time.
// Reset clears references, pipeline flags, slot occupancy and the unload chain.
module nearest_eight_point_select_unit #(
    parameter int KEEP_COUNT = neps_pkg::KEEP_COUNT_DEF,
    parameter int COORD_BITS = neps_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [neps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]          i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [COORD_BITS-1:0]          i_point_x,
    input  logic [COORD_BITS-1:0]          i_point_y,
    input  logic [COORD_BITS-1:0]          i_point_z,
    input  logic                           i_final_point,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [COORD_BITS-1:0]          o_near_x,
    output logic [COORD_BITS-1:0]          o_near_y,
    output logic [COORD_BITS-1:0]          o_near_z,
    output logic [neps_pkg::RANK_W-1:0]    o_rank,
    output logic [2*COORD_BITS+1:0]        o_dist_squared,
    output logic                           o_end_of_list
);
    import neps_pkg::*;

    `include "nearest_eight_point_select_unit_assert.svh"

    localparam int DIST_W = 2 * COORD_BITS + 2;

    logic [COORD_BITS-1:0] r_ref_x, r_ref_y, r_ref_z;

    logic                  w_en;
    logic                  w_s4_vld, w_s4_fin;
    logic [DIST_W-1:0]     w_s4_dist;
    logic [COORD_BITS-1:0] w_s4_x, w_s4_y, w_s4_z;
    logic                  w_can_load;
    t_cell_ctl             w_ctl;

    // Neighbor links; index 0 is the tie-off in front of the first cell.
    logic                  w_lt [KEEP_COUNT+1];
    logic                  w_cf [KEEP_COUNT+1];
    logic [DIST_W-1:0]     w_cd [KEEP_COUNT+1];
    logic [COORD_BITS-1:0] w_cx [KEEP_COUNT+1];
    logic [COORD_BITS-1:0] w_cy [KEEP_COUNT+1];
    logic [COORD_BITS-1:0] w_cz [KEEP_COUNT+1];

    logic [KEEP_COUNT-1:0]                 w_cell_full;
    logic [KEEP_COUNT-1:0]                 w_nf;
    logic [KEEP_COUNT-1:0][DIST_W-1:0]     w_nd;
    logic [KEEP_COUNT-1:0][COORD_BITS-1:0] w_nx, w_ny, w_nz;

    // Reference position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x <= '0;
            r_ref_y <= '0;
            r_ref_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF_X: r_ref_x <= i_cfg_data;
                CFG_REF_Y: r_ref_y <= i_cfg_data;
                CFG_REF_Z: r_ref_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline only stops for a final request that cannot hand its list off yet.
    assign w_en       = !(w_s4_vld && w_s4_fin && !w_can_load);
    assign o_in_ready = w_en;
    assign w_ctl.ins  = w_s4_vld && w_en;
    assign w_ctl.clr  = w_s4_vld && w_en && w_s4_fin;

    neps_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .i_z     (i_point_z),
        .i_final (i_final_point),
        .i_ref_x (r_ref_x),
        .i_ref_y (r_ref_y),
        .i_ref_z (r_ref_z),
        .o_vld   (w_s4_vld),
        .o_final (w_s4_fin),
        .o_dist  (w_s4_dist),
        .o_x     (w_s4_x),
        .o_y     (w_s4_y),
        .o_z     (w_s4_z)
    );

    assign w_lt[0] = 1'b0;
    assign w_cf[0] = 1'b0;
    assign w_cd[0] = '0;
    assign w_cx[0] = '0;
    assign w_cy[0] = '0;
    assign w_cz[0] = '0;

    // Sorted insertion chain, nearest entry in cell 0.
    for (genvar k = 0; k < KEEP_COUNT; k++) begin : g_cell
        neps_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_dist      (w_s4_dist),
            .i_x         (w_s4_x),
            .i_y         (w_s4_y),
            .i_z         (w_s4_z),
            .i_lt_prev   (w_lt[k]),
            .i_prev_full (w_cf[k]),
            .i_prev_dist (w_cd[k]),
            .i_prev_x    (w_cx[k]),
            .i_prev_y    (w_cy[k]),
            .i_prev_z    (w_cz[k]),
            .o_lt        (w_lt[k+1]),
            .o_full      (w_cf[k+1]),
            .o_dist      (w_cd[k+1]),
            .o_x         (w_cx[k+1]),
            .o_y         (w_cy[k+1]),
            .o_z         (w_cz[k+1]),
            .o_nxt_full  (w_nf[k]),
            .o_nxt_dist  (w_nd[k]),
            .o_nxt_x     (w_nx[k]),
            .o_nxt_y     (w_ny[k]),
            .o_nxt_z     (w_nz[k])
        );
        assign w_cell_full[k] = w_cf[k+1];
    end

    neps_drain #(
        .KEEP_COUNT (KEEP_COUNT),
        .COORD_BITS (COORD_BITS)
    ) u_drain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_ctl.clr),
        .i_full     (w_nf),
        .i_dist     (w_nd),
        .i_x        (w_nx),
        .i_y        (w_ny),
        .i_z        (w_nz),
        .o_can_load (w_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_x        (o_near_x),
        .o_y        (o_near_y),
        .o_z        (o_near_z),
        .o_rank     (o_rank),
        .o_dist     (o_dist_squared),
        .o_last     (o_end_of_list)
    );

    // Occupied slots always form a prefix starting at cell 0.
    `NEPS_ASSERT_NOW(a_full_prefix, i_clk, i_rst_n, 1'b1,
        (w_cell_full & (w_cell_full + KEEP_COUNT'(1))) == '0)
    // A list that was handed off leaves the sort chain empty.
    `NEPS_ASSERT_NEXT(a_clear_after_final, i_clk, i_rst_n, w_ctl.clr, w_cell_full == '0)
    // The input is held back only by a waiting final request and a busy unload chain.
    `NEPS_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
        w_s4_vld && w_s4_fin && o_out_valid)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the nearest eight point select unit.
module tb_top;
    import neps_pkg::*;

    localparam int CW          = 24;
    localparam int KEEP        = 8;
    localparam int DW          = 2 * CW + 2;
    localparam int SETTLE_CYC  = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 105;
    localparam int HOLD_CYC    = 300;

    // The index after the three reference registers selects nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    localparam logic [CW-1:0] C_MIN  = 24'h800000;
    localparam logic [CW-1:0] C_MAX  = 24'h7FFFFF;
    localparam logic [CW-1:0] C_NEG1 = 24'hFFFFFF;

    // How a random coordinate is drawn.
    typedef enum int {
        PT_NEAR,
        PT_WIDE,
        PT_EDGE
    } t_point_mode;

    // One emitted entry of the nearest list.
    typedef struct {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic [2:0]    rank;
        logic [DW-1:0] sq_dist;
        logic          eol;
    } t_near_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CW-1:0]        i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [CW-1:0]        i_point_x = '0;
    logic [CW-1:0]        i_point_y = '0;
    logic [CW-1:0]        i_point_z = '0;
    logic                 i_final_point = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [CW-1:0]        o_near_x;
    logic [CW-1:0]        o_near_y;
    logic [CW-1:0]        o_near_z;
    logic [RANK_W-1:0]    o_rank;
    logic [DW-1:0]        o_dist_squared;
    logic                 o_end_of_list;

    // Predictor state: reference position and the kept list.
    logic [CW-1:0] ref_pos [3];
    logic [DW-1:0] kept_dist [KEEP];
    logic [CW-1:0] kept_x [KEEP];
    logic [CW-1:0] kept_y [KEEP];
    logic [CW-1:0] kept_z [KEEP];
    logic          kept_used [KEEP];

    t_near_result pending_near [$];
    t_near_result want_near;

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  items_sent = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    int  rx_hold = 0;

    nearest_eight_point_select_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_final_point  (i_final_point),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_near_x       (o_near_x),
        .o_near_y       (o_near_y),
        .o_near_z       (o_near_z),
        .o_rank         (o_rank),
        .o_dist_squared (o_dist_squared),
        .o_end_of_list  (o_end_of_list)
    );

    always #5 i_clk = ~i_clk;

    // Run-away guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Exact squared distance of a point to the current reference.
    function automatic logic [DW-1:0] dist_to_ref(logic [CW-1:0] px, logic [CW-1:0] py,
                                                  logic [CW-1:0] pz);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(px)) - longint'($signed(ref_pos[0]));
        dy = longint'($signed(py)) - longint'($signed(ref_pos[1]));
        dz = longint'($signed(pz)) - longint'($signed(ref_pos[2]));
        return DW'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Insert one point into the kept list; on a final point emit and clear the list.
    task automatic predict_nearest(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                                   logic fin);
        logic [DW-1:0] d;
        int            slot;
        int            n;
        t_near_result  r;
        d = dist_to_ref(px, py, pz);
        slot = 0;
        // Ties keep the earlier point in front.
        while (slot < KEEP && kept_used[slot] && d >= kept_dist[slot])
            slot++;
        if (slot < KEEP) begin
            for (int j = KEEP - 1; j > slot; j--) begin
                kept_dist[j] = kept_dist[j-1];
                kept_x[j]    = kept_x[j-1];
                kept_y[j]    = kept_y[j-1];
                kept_z[j]    = kept_z[j-1];
                kept_used[j] = kept_used[j-1];
            end
            kept_dist[slot] = d;
            kept_x[slot]    = px;
            kept_y[slot]    = py;
            kept_z[slot]    = pz;
            kept_used[slot] = 1'b1;
        end
        if (fin) begin
            n = 0;
            for (int i = 0; i < KEEP; i++)
                if (kept_used[i])
                    n++;
            for (int i = 0; i < n; i++) begin
                r.x       = kept_x[i];
                r.y       = kept_y[i];
                r.z       = kept_z[i];
                r.rank    = 3'(i);
                r.sq_dist = kept_dist[i];
                r.eol     = (i == n - 1);
                pending_near.insert(pending_near.size(), r);
            end
            for (int i = 0; i < KEEP; i++)
                kept_used[i] = 1'b0;
        end
    endtask

    // Offer one request, after a random lead-in gap while tx_idle is set, and wait until it is taken.
    task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz,
                              logic fin);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_z     <= pz;
        i_final_point <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        predict_nearest(px, py, pz, fin);
        items_sent++;
    endtask

    // Stop offering, wait for every expected result, then let the pipeline settle.
    task automatic drain_all();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_near.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // Write one configuration register; only called while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_REF_X: ref_pos[0] = data;
            CFG_REF_Y: ref_pos[1] = data;
            CFG_REF_Z: ref_pos[2] = data;
            default: ;
        endcase
    endtask

    task automatic write_ref(logic [CW-1:0] rx, logic [CW-1:0] ry, logic [CW-1:0] rz);
        write_reg(CFG_REF_X, rx);
        write_reg(CFG_REF_Y, ry);
        write_reg(CFG_REF_Z, rz);
    endtask

    function automatic logic [CW-1:0] edge_coord();
        case ($urandom_range(0, 4))
            0: return C_MIN;
            1: return C_MAX;
            2: return '0;
            3: return C_NEG1;
            default: return 24'd1;
        endcase
    endfunction

    // Random coordinate: close to the reference (many ties), anywhere, or at an edge.
    function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] center, t_point_mode mode);
        case (mode)
            PT_NEAR: return center + CW'($urandom_range(0, 6)) - CW'(3);
            PT_WIDE: return CW'($urandom);
            default: return edge_coord();
        endcase
    endfunction

    // Receiver: a random gap before each result while rx_idle is set, or a long hold-off on request.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold <= 0;
            end else begin
                gap = rx_idle ? $urandom_range(0, 7) : 0;
                if (gap != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready) && rx_hold == 0);
        end
    end

    function automatic void check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each taken result with the oldest expected entry.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_near.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual rank %0d dist %h",
                         $time, o_rank, o_dist_squared);
                mismatch_count++;
            end else begin
                want_near = pending_near.pop_front();
                check_field("near_x", DW'(want_near.x), DW'(o_near_x));
                check_field("near_y", DW'(want_near.y), DW'(o_near_y));
                check_field("near_z", DW'(want_near.z), DW'(o_near_z));
                check_field("rank", DW'(want_near.rank), DW'(o_rank));
                check_field("dist_squared", want_near.sq_dist, o_dist_squared);
                check_field("end_of_list", DW'(want_near.eol), DW'(o_end_of_list));
            end
        end
    end

    // A lone final point at the reset reference gives one entry at distance zero.
    task automatic test_reset_origin();
        send_point('0, '0, '0, 1'b1);
        drain_all();
    endtask

    // Opposite corners give the largest distance; matching corners give zero.
    task automatic test_extreme_distance();
        write_ref(C_MAX, C_MAX, C_MAX);
        send_point(C_MIN, C_MIN, C_MIN, 1'b1);
        drain_all();
        write_ref(C_MIN, C_MIN, C_MIN);
        send_point(C_MAX, C_MAX, C_MAX, 1'b0);
        send_point(C_MIN, C_MIN, C_MIN, 1'b1);
        drain_all();
    endtask

    // Overfill the list: drops of the farthest, a tie behind the earlier point,
    // and a final point that ties the farthest entry and is discarded.
    task automatic test_full_list_and_ties();
        write_ref('0, '0, '0);
        for (int v = 9; v >= 2; v--)
            send_point(CW'(v), '0, '0, 1'b0);
        send_point(-CW'(5), '0, '0, 1'b0);
        send_point('0, 24'd1, '0, 1'b0);
        send_point('0, 24'd7, '0, 1'b1);
        drain_all();
    endtask

    // Stored distances keep the reference in force when they were inserted.
    task automatic test_ref_change_mid_set();
        send_point(24'd100, '0, '0, 1'b0);
        send_point(-CW'(50), '0, '0, 1'b0);
        drain_all();
        write_reg(CFG_REF_X, 24'd1000);
        send_point(24'd900, '0, '0, 1'b1);
        drain_all();
    endtask

    // A write to the spare index changes nothing.
    task automatic test_spare_index();
        write_reg(CFG_IDX_SPARE, C_NEG1);
        send_point(24'd3, 24'd4, '0, 1'b1);
        drain_all();
    endtask

    // Random sets of random length, with new references between some of them.
    task automatic test_random_sets();
        int          len;
        t_point_mode mode;
        int          start;
        start = items_sent;
        while (items_sent - start < RAND_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                drain_all();
                write_ref(($urandom_range(0, 3) == 0) ? edge_coord() : CW'($urandom),
                          ($urandom_range(0, 3) == 0) ? edge_coord() : CW'($urandom),
                          ($urandom_range(0, 3) == 0) ? edge_coord() : CW'($urandom));
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_IDX_SPARE, CW'($urandom));
            end
            tx_idle = ($urandom_range(0, 9) < 7);
            rx_idle <= ($urandom_range(0, 9) < 7);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: mode = PT_NEAR;
                    5, 6, 7:       mode = PT_WIDE;
                    default:       mode = PT_EDGE;
                endcase
                send_point(pick_coord(ref_pos[0], mode), pick_coord(ref_pos[1], mode),
                           pick_coord(ref_pos[2], mode), k == len - 1);
            end
        end
        drain_all();
    endtask

    // Long receiver hold-off while several short sets arrive, so the input stalls.
    task automatic test_backpressure();
        tx_idle = 1'b0;
        @(negedge i_clk);
        rx_hold <= HOLD_CYC;
        for (int s = 0; s < 5; s++)
            for (int k = 0; k < 4; k++)
                send_point(pick_coord(ref_pos[0], PT_NEAR), CW'($urandom),
                           pick_coord(ref_pos[2], PT_NEAR), k == 3);
        drain_all();
    endtask

    // The sender waits for every result of one set before the next, without idling.
    task automatic test_sender_pause();
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 10; k++)
                send_point(pick_coord(ref_pos[0], PT_NEAR), pick_coord(ref_pos[1], PT_NEAR),
                           pick_coord(ref_pos[2], PT_NEAR), k == 9);
            drain_all();
        end
        tx_idle = 1'b1;
        rx_idle <= 1'b1;
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin
        for (int i = 0; i < 3; i++)
            ref_pos[i] = '0;
        for (int i = 0; i < KEEP; i++)
            kept_used[i] = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_origin();
        test_extreme_distance();
        test_full_list_and_ties();
        test_ref_change_mid_set();
        test_spare_index();
        test_random_sets();
        test_backpressure();
        test_sender_pause();
        drain_all();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
